>>> rtl/resmp_pkg.sv
// ============================================================================
// resmp_pkg - shared types and constants for the nearest sample resampler
// Register indexes, field widths, chunk geometry and the control and status
// bundles passed between the sequencer and the phase unit.
// ============================================================================
package resmp_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 12;
    localparam int COUNT_W  = 24;
    localparam int PHASE_W  = 32;
    localparam int OFFSET_W = 10;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 2;

    // Chunk geometry (power of two)
    localparam int CHUNK_SAMPLES = 1024;
    localparam int CHUNK_BITS    = $clog2(CHUNK_SAMPLES);

    // Results produced for one input word at most
    localparam int MAX_RESULTS = 64;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT = 2'd2;

    // Reset values of the configuration registers
    localparam logic [STEP_W-1:0]  PHASE_STEP_RST   = 12'd256;
    localparam logic               WIDE_SAMPLES_RST = 1'b1;
    localparam logic [COUNT_W-1:0] OUTPUT_COUNT_RST = 24'd0;

    // Sequencer commands to the phase unit
    typedef struct packed {
        logic load;    // take a new input word
        logic clear;   // start of sound: zero phase and counters on load
        logic emit;    // produce one output and advance phase
        logic finish;  // advance the input index, word is done
    } resmp_ctrl_t;

    // Phase unit status to the sequencer
    typedef struct packed {
        logic more;    // an output is pending for the current input index
    } resmp_stat_t;

endpackage

>>> rtl/nearest_sample_resampler.sv
// ============================================================================
// nearest_sample_resampler - nearest-neighbour audio resampler, 4.8 step
// Top level: configuration registers, sequencer, phase unit, output register.
// ============================================================================
// An input word is accepted, then makes k outputs (at most 64), each through
// the shared compare and phase add step, and is then retired. An output
// waits in a single output register, so a stalled output side holds the step
// loop; s_axis_tready is low while a word is in work. Output k takes input
// floor(k * phase_step / 256), or a later word if the per-word limit is hit;
// tuser on the input restarts the sound.
// Configuration must be written only while no word is in work.
module nearest_sample_resampler import resmp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // Input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // [15:0] raw_sample
    input  logic                 s_axis_tuser,   // [0] start_of_sound
    // Output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,   // [15:0] out_sample,
                                                 // [25:16] chunk_offset, [31:26] zero
    output logic                 m_axis_tuser,   // [0] new_chunk
    output logic                 m_axis_tlast    // last_output
);

    logic [STEP_W-1:0]   phase_step_reg;
    logic                wide_samples_reg;
    logic [COUNT_W-1:0]  output_count_reg;

    resmp_ctrl_t         ctrl;
    resmp_stat_t         stat;
    logic                out_free;

    logic [SAMPLE_W-1:0] res_sample;
    logic [OFFSET_W-1:0] res_offset;
    logic                res_new_chunk;
    logic                res_last;

    logic                mvalid_reg;
    logic [SAMPLE_W-1:0] msample_reg;
    logic [OFFSET_W-1:0] moffset_reg;
    logic                mnew_reg;
    logic                mlast_reg;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg   <= PHASE_STEP_RST;
            wide_samples_reg <= WIDE_SAMPLES_RST;
            output_count_reg <= OUTPUT_COUNT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PHASE_STEP:   phase_step_reg   <= cfg_data[STEP_W-1:0];
                REG_WIDE_SAMPLES: wide_samples_reg <= cfg_data[0];
                REG_OUTPUT_COUNT: output_count_reg <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_free = !mvalid_reg || m_axis_tready;

    resmp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_start (s_axis_tuser),
        .in_ready (s_axis_tready),
        .out_free (out_free),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    resmp_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .raw_sample    (s_axis_tdata),
        .phase_step    (phase_step_reg),
        .wide_samples  (wide_samples_reg),
        .output_count  (output_count_reg),
        .stat          (stat),
        .res_sample    (res_sample),
        .res_offset    (res_offset),
        .res_new_chunk (res_new_chunk),
        .res_last      (res_last)
    );

    // Output register: load on emit, drop when the word is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (ctrl.emit) begin
            mvalid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit) begin
            msample_reg <= res_sample;
            moffset_reg <= res_offset;
            mnew_reg    <= res_new_chunk;
            mlast_reg   <= res_last;
        end
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = {6'b0, moffset_reg, msample_reg};
    assign m_axis_tuser  = mnew_reg;
    assign m_axis_tlast  = mlast_reg;

endmodule

>>> rtl/resmp_core.sv
// ============================================================================
// resmp_core - phase unit of the nearest sample resampler
// Holds the phase accumulator, input and output indexes and the current
// sample. One compare and add step runs per cycle under sequencer control, while the output register has room.
// ============================================================================
module resmp_core import resmp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  resmp_ctrl_t          ctrl,
    input  logic [SAMPLE_W-1:0]  raw_sample,
    input  logic [STEP_W-1:0]    phase_step,
    input  logic                 wide_samples,
    input  logic [COUNT_W-1:0]   output_count,
    output resmp_stat_t          stat,
    output logic [SAMPLE_W-1:0]  res_sample,
    output logic [OFFSET_W-1:0]  res_offset,
    output logic                 res_new_chunk,
    output logic                 res_last
);

    logic [PHASE_W-1:0]    phase_reg, phase_next;
    logic [COUNT_W-1:0]    iidx_reg, iidx_next;
    logic [COUNT_W-1:0]    oidx_reg, oidx_next;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [SAMPLE_W-1:0]   conv_sample;
    logic [CHUNK_BITS-1:0] chunk_pos;

    // In 8-bit mode convert the byte format: flip the sign bit and move to the top byte
    assign conv_sample = wide_samples ? raw_sample
                                      : {~raw_sample[7], raw_sample[6:0], 8'h00};

    // Shared compare: count not reached and phase integer part at or below index
    assign stat.more = (oidx_reg < output_count) &&
                       (phase_reg[PHASE_W-1:8] <= iidx_reg);

    // Next state of the phase and both indexes
    always_comb begin
        phase_next = phase_reg;
        iidx_next  = iidx_reg;
        oidx_next  = oidx_reg;
        if (ctrl.load && ctrl.clear) begin
            phase_next = '0;
            iidx_next  = '0;
            oidx_next  = '0;
        end else if (ctrl.emit) begin
            phase_next = phase_reg + {{(PHASE_W-STEP_W){1'b0}}, phase_step};
            oidx_next  = oidx_reg + 1'b1;
        end else if (ctrl.finish) begin
            iidx_next = iidx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            iidx_reg  <= '0;
            oidx_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            iidx_reg  <= iidx_next;
            oidx_reg  <= oidx_next;
        end
    end

    // Hold the converted sample for all outputs of this word
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            sample_reg <= conv_sample;
        end
    end

    // Result fields for the output about to be emitted
    assign chunk_pos     = oidx_reg[CHUNK_BITS-1:0];
    assign res_sample    = sample_reg;
    assign res_offset    = OFFSET_W'(chunk_pos);
    assign res_new_chunk = (chunk_pos == '0);
    assign res_last      = ((oidx_reg + 1'b1) == output_count);

endmodule

>>> rtl/resmp_ctrl.sv
// ============================================================================
// resmp_ctrl - sequencer of the nearest sample resampler
// Accepts one input word, then steps the phase unit once per output until no
// output is pending or the per-word limit is hit, then retires the word.
// ============================================================================
module resmp_ctrl import resmp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic        in_start,
    output logic        in_ready,
    input  logic        out_free,
    input  resmp_stat_t stat,
    output resmp_ctrl_t ctrl
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                 state_reg, state_next;
    logic [RES_CNT_W-1:0] nres_reg, nres_next;
    logic                 go;

    assign in_ready = (state_reg == ST_IDLE);

    // Another output is due for this word
    assign go = stat.more && (nres_reg < RES_CNT_W'(MAX_RESULTS));

    always_comb begin
        ctrl        = '0;
        state_next  = state_reg;
        nres_next   = nres_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    ctrl.load  = 1'b1;
                    ctrl.clear = in_start;
                    nres_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (go) begin
                    // stall while the output register is still full
                    if (out_free) begin
                        ctrl.emit = 1'b1;
                        nres_next = nres_reg + 1'b1;
                    end
                end else begin
                    ctrl.finish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            nres_reg  <= '0;
        end else begin
            state_reg <= state_next;
            nres_reg  <= nres_next;
        end
    end

endmodule

>>> rtl/resmp_checker.sv
// ============================================================================
// resmp_checker - port-level checks for the nearest sample resampler
// Watches the stream ports and flags handshake and field consistency slips.
// ============================================================================
module resmp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // A stalled output word stays valid
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    // Busy after taking an input word
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    // New-chunk flag agrees with a zero chunk offset
    a_chunk_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[25:16] == 10'd0)))
        else $error("new_chunk does not match chunk_offset");

    // Padding bits of the output word stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[31:26] == 6'd0))
        else $error("output padding bits not zero");

endmodule

bind nearest_sample_resampler resmp_checker u_resmp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> tb/tb_nearest_sample_resampler.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_nearest_sample_resampler - self-checking bench for the sample resampler
// Drives input words with random gaps, stalls the output side at random and
// predicts every output word from a cycle-free model of the phase accumulator.
// Output words are compared field by field in order. The run steps through
// several register settings: defaults, 8-bit mode, zero step, a sound long
// enough to cross a chunk boundary, and random settings.
// ============================================================================
module tb_nearest_sample_resampler;
    import resmp_pkg::*;

    localparam int ITEMS        = 270;   // input words the run sends at least
    localparam int SETTLE_CYCLES = 8;    // idle cycles before a register write
    localparam int HOLD_CYCLES  = 300;   // one long output stall
    localparam int HOLD_AFTER   = 300;   // output words seen before that stall
    localparam int QUIET_LIMIT  = 4000;  // cycles without any transfer or register write

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata;   // [15:0] raw_sample
    logic                 s_axis_tuser;   // [0] start_of_sound
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [31:0]          m_axis_tdata;   // [15:0] out_sample, [25:16] chunk_offset,
                                          // [31:26] zero
    logic                 m_axis_tuser;   // [0] new_chunk
    logic                 m_axis_tlast;   // last_output

    // One expected output word
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [OFFSET_W-1:0] offset;
        logic                new_chunk;
        logic                last_out;
    } resample_word_t;

    // Phase accumulator model and the queue of output words it predicts
    class resample_scoreboard;
        logic [STEP_W-1:0]   step;
        logic                wide;
        logic [COUNT_W-1:0]  count;
        logic [PHASE_W-1:0]  phase;
        logic [COUNT_W-1:0]  in_idx;
        logic [COUNT_W-1:0]  out_idx;
        resample_word_t      pending_words[$];
        int                  errors;
        int                  n_inputs;
        int                  n_checked;

        function new();
            step      = PHASE_STEP_RST;
            wide      = WIDE_SAMPLES_RST;
            count     = OUTPUT_COUNT_RST;
            phase     = '0;
            in_idx    = '0;
            out_idx   = '0;
            errors    = 0;
            n_inputs  = 0;
            n_checked = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_PHASE_STEP:   step  = val[STEP_W-1:0];
                REG_WIDE_SAMPLES: wide  = val[0];
                REG_OUTPUT_COUNT: count = val[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Emit pending outputs whose phase integer part has been reached, up to the per-word limit and the output count
        function void note_input(logic [15:0] raw, logic sos);
            logic [SAMPLE_W-1:0] smp;
            resample_word_t      w;
            int                  n;
            if (sos) begin
                phase   = '0;
                in_idx  = '0;
                out_idx = '0;
            end
            smp = wide ? raw : {raw[7:0] ^ 8'h80, 8'h00};
            n = 0;
            while (n < MAX_RESULTS && out_idx < count && phase[PHASE_W-1:8] <= in_idx) begin
                w.sample    = smp;
                w.offset    = OFFSET_W'(out_idx % CHUNK_SAMPLES);
                w.new_chunk = (out_idx % CHUNK_SAMPLES) == 0;
                w.last_out  = (out_idx + 1'b1) == count;
                pending_words.push_back(w);
                phase   = phase + PHASE_W'(step);
                out_idx = out_idx + 1'b1;
                n++;
            end
            in_idx = in_idx + 1'b1;
            n_inputs++;
        endfunction

        function void check_result(logic [31:0] data, logic user, logic last);
            resample_word_t w;
            n_checked++;
            if (pending_words.size() == 0) begin
                $error("output word with nothing expected: tdata %h", data);
                errors++;
                return;
            end
            w = pending_words.pop_front();
            if (data[15:0] !== w.sample) begin
                $error("out_sample: expected %0d, got %0d", $signed(w.sample),
                       $signed(data[15:0]));
                errors++;
            end
            if (data[25:16] !== w.offset) begin
                $error("chunk_offset: expected %0d, got %0d", w.offset, data[25:16]);
                errors++;
            end
            if (data[31:26] !== 6'd0) begin
                $error("tdata padding: expected %0d, got %0d", 0, data[31:26]);
                errors++;
            end
            if (user !== w.new_chunk) begin
                $error("new_chunk: expected %0d, got %0d", w.new_chunk, user);
                errors++;
            end
            if (last !== w.last_out) begin
                $error("last_output: expected %0d, got %0d", w.last_out, last);
                errors++;
            end
        endfunction
    endclass

    resample_scoreboard sb = new;
    int n_sent     = 0;
    int n_settings = 0;
    int send_burst = 0;
    int quiet      = 0;

    nearest_sample_resampler DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Gap before the next word: mostly random, sometimes a burst without gaps
    function automatic int draw_gap(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            burst = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    // Write all three registers, one per cycle; the block is idle here
    task automatic set_config(input logic [STEP_W-1:0] step, input logic wide,
                              input logic [COUNT_W-1:0] count);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_PHASE_STEP;
        cfg_data  <= CFG_W'(step);
        @(posedge aclk);
        sb.set_register(REG_PHASE_STEP, CFG_W'(step));
        cfg_index <= REG_WIDE_SAMPLES;
        cfg_data  <= CFG_W'(wide);
        @(posedge aclk);
        sb.set_register(REG_WIDE_SAMPLES, CFG_W'(wide));
        cfg_index <= REG_OUTPUT_COUNT;
        cfg_data  <= CFG_W'(count);
        @(posedge aclk);
        sb.set_register(REG_OUTPUT_COUNT, CFG_W'(count));
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // Offer one input word and hold it until the block takes it
    task automatic send_word(input logic [15:0] raw, input logic sos);
        int gap;
        gap = draw_gap(send_burst);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        s_axis_tuser  <= sos;
        do @(posedge aclk); while (!s_axis_tready);
        n_sent++;
    endtask

    // Drop valid, wait for every predicted word and for the block to go idle
    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_words.size() != 0 || !s_axis_tready) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Stimulus
    initial begin
        logic [STEP_W-1:0]  step;
        logic [COUNT_W-1:0] count;
        logic               sos;
        int                 len;
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= REG_PHASE_STEP;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: output count is zero, so nothing comes out
        send_word(16'h1234, 1'b1);
        send_word(16'hFFFF, 1'b0);
        finish_phase();

        // 16-bit extremes at unity step
        set_config(12'd256, 1'b1, 24'd40);
        send_word(16'h0000, 1'b1);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h5A5A, 1'b0);
        send_word(16'hA5A5, 1'b0);
        finish_phase();

        // 8-bit mode at half rate; upper byte junk, last word past the count
        set_config(12'd512, 1'b0, 24'd4);
        send_word(16'hAB00, 1'b1);
        send_word(16'h0033, 1'b0);
        send_word(16'h12FF, 1'b0);
        send_word(16'h00CC, 1'b0);
        send_word(16'hFF80, 1'b0);
        send_word(16'h3C3C, 1'b0);
        send_word(16'h007F, 1'b0);
        send_word(16'hFFFF, 1'b0);
        finish_phase();

        // Zero step: first word hits the per-word cap, the rest spill over
        set_config(12'd0, 1'b1, 24'd70);
        send_word(16'h4321, 1'b1);
        send_word(16'hBEEF, 1'b0);
        finish_phase();

        // Smallest legal step, long enough to cross a chunk boundary
        set_config(12'd4, 1'($urandom_range(0, 1)), 24'd1100);
        for (int i = 0; i < 20; i++) begin
            send_word(16'($urandom_range(0, 65535)), i == 0);
        end
        finish_phase();

        // Random settings; most sounds restart, some keep going across the write
        while (n_sent < ITEMS) begin
            case ($urandom_range(0, 9))
                0:       step = 12'd4;
                1:       step = 12'd4095;
                2:       step = 12'($urandom_range(0, 3));
                3, 4:    step = 12'($urandom_range(4, 64));
                default: step = 12'($urandom_range(65, 4095));
            endcase
            case ($urandom_range(0, 9))
                0:       count = 24'd0;
                1:       count = 24'hFFFFFF;
                2:       count = 24'($urandom_range(1, 8));
                default: count = 24'($urandom_range(1, 300));
            endcase
            set_config(step, 1'($urandom_range(0, 1)), count);
            len = $urandom_range(8, 30);
            for (int i = 0; i < len; i++) begin
                if (i == 0)
                    sos = $urandom_range(0, 3) != 0;
                else
                    sos = $urandom_range(0, 19) == 0;
                send_word(16'($urandom_range(0, 65535)), sos);
            end
            finish_phase();
        end

        $display("covered %0d input words and %0d output words", sb.n_inputs, sb.n_checked);
        $display("over %0d register settings, with one long output stall", n_settings);
        if (sb.errors == 0 && sb.pending_words.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Output side: random stalls, bursts, and one long hold-off to back up the block
    initial begin
        int gap;
        int burst;
        bit held;
        m_axis_tready <= 1'b0;
        burst = 0;
        held  = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = draw_gap(burst);
            if (!held && sb.n_checked >= HOLD_AFTER) begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    // Predict on every accepted input word
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            sb.note_input(s_axis_tdata, s_axis_tuser);
        end
    end

    // Check every accepted output word
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

endmodule
